>>> sv/cas_pkg.sv
// shared types and constants for the cave smoothing automaton
`timescale 1ns / 1ps
package cas_pkg;

    // field widths of the stream items
    localparam int OP_W    = 2;
    localparam int IDX_W   = 5;
    localparam int CELLS_W = 36;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    // request kinds
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_ABOVE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_BELOW = 2'd2;

    localparam logic [CFG_DATA_W-1:0] PASS_COUNT_RST  = 4'd3;
    localparam logic [CFG_DATA_W-1:0] FILL_ABOVE_RST  = 4'd4;
    localparam logic [CFG_DATA_W-1:0] CLEAR_BELOW_RST = 4'd4;

    // thresholds handed to every lane
    typedef struct packed {
        logic [CFG_DATA_W-1:0] fill_above;
        logic [CFG_DATA_W-1:0] clear_below;
    } t_rule;

endpackage

>>> sv/cas_cell.sv
// one lane: neighbour count and fill/clear rule for a single cell
`timescale 1ns / 1ps
module cas_cell (
    input  logic [7:0]          i_nbr,
    input  logic                i_here,
    input  cas_pkg::t_rule      i_rule,
    output logic                o_cell
);
    import cas_pkg::*;

    logic [3:0] count;

    always_comb begin
        count = '0;
        for (int k = 0; k < 8; k++) begin
            count = count + 4'(i_nbr[k]);
        end
    end

    // fill rule wins when both rules hold
    always_comb begin
        priority if (count > i_rule.fill_above) begin
            o_cell = 1'b1;
        end else if (count >= i_rule.clear_below) begin
            o_cell = i_here;
        end else begin
            o_cell = 1'b0;
        end
    end

endmodule

>>> sv/cas_row.sv
// all columns of one row smoothed side by side, lane results merged into a row
`timescale 1ns / 1ps
module cas_row #(
    parameter int COLS = 36
) (
    input  logic [COLS-1:0]     i_above,
    input  logic [COLS-1:0]     i_here,
    input  logic [COLS-1:0]     i_below,
    input  cas_pkg::t_rule      i_rule,
    output logic [COLS-1:0]     o_row
);
    import cas_pkg::*;

    // zero column on each side for the grid border
    logic [COLS+1:0] above_ext;
    logic [COLS+1:0] here_ext;
    logic [COLS+1:0] below_ext;
    logic [COLS-1:0] lane_bit;

    assign above_ext = {1'b0, i_above, 1'b0};
    assign here_ext  = {1'b0, i_here, 1'b0};
    assign below_ext = {1'b0, i_below, 1'b0};

    for (genvar x = 0; x < COLS; x++) begin : g_lane
        cas_cell u_cell (
            .i_nbr  ({above_ext[x+2:x], here_ext[x+2], here_ext[x], below_ext[x+2:x]}),
            .i_here (i_here[x]),
            .i_rule (i_rule),
            .o_cell (lane_bit[x])
        );
    end

    // merge lanes into the new row
    always_comb begin
        o_row = '0;
        for (int x = 0; x < COLS; x++) begin
            o_row[x] = lane_bit[x];
        end
    end

endmodule

>>> sv/cave_automaton_smoothing.sv
// top level: grid memory, request sequencer and result register
//
// Usage:
//   Input items arrive on the s_axis group. tuser carries the request kind
//   (0 write row, 1 run smoothing passes, 2 read row); tdata carries the row
//   index and the row cells. Every accepted item gives exactly one result item
//   on the m_axis group: tuser echoes the kind, tdata holds the row for a read
//   and zero otherwise. Writes and reads to a row index outside the grid are
//   ignored and read back as zero.
//   Thresholds and the pass count sit on the i_cfg write port; write them only
//   while no request is in flight.
// Sequencing:
//   a write or an unused kind finishes in the cycle that accepts it, a read
//   once its row has been read from the grid memory. A run makes pass_count
//   passes: each pass streams the rows through the single read port of the
//   grid memory, one row per cycle, and all columns of a row are smoothed at
//   once. One request is worked on at a time; the next one is taken as soon as
//   the current one has finished.
// Reset clears the grid (per-row valid bits) and the result register and sets
// configuration defaults. When the receiver stalls, a finished result waits in
// the output register while the next request is taken; a second result waits
// in a holding register and the input stalls until the output drains.
`timescale 1ns / 1ps
module cave_automaton_smoothing #(
    parameter int GRID_COLS = 36,
    parameter int GRID_ROWS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [cas_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cas_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cas_pkg::IN_DATA_W-1:0]       s_axis_tdata,   // row_index, row_cells
    input  logic [cas_pkg::OP_W-1:0]            s_axis_tuser,   // op
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cas_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // row_out
    output logic [cas_pkg::OP_W-1:0]            m_axis_tuser    // done_op
);
    import cas_pkg::*;

    localparam int AW = $clog2(GRID_ROWS);
    localparam int SW = $clog2(GRID_ROWS + 2);
    localparam logic [SW-1:0] STEP_ROWS = SW'(GRID_ROWS);
    localparam logic [SW-1:0] STEP_LAST = SW'(GRID_ROWS + 1);
    localparam logic [SW-1:0] STEP_WB   = SW'(2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RUN,
        ST_HOLD
    } t_state;

    t_state                 r_state;
    logic [SW-1:0]          r_step;
    logic [CFG_DATA_W-1:0]  r_pass;
    logic [CFG_DATA_W-1:0]  r_pass_count;
    t_rule                  r_rule;
    logic                   r_rd_inrange;

    logic                   r_out_valid;
    logic [OP_W-1:0]        r_out_op;
    logic [CELLS_W-1:0]     r_out_row;
    logic [OP_W-1:0]        r_pend_op;
    logic [CELLS_W-1:0]     r_pend_row;

    logic [GRID_COLS-1:0]   mem [GRID_ROWS];
    logic [GRID_ROWS-1:0]   r_valid;
    logic [GRID_COLS-1:0]   r_rd_data;
    logic                   r_rd_vld;
    logic [GRID_COLS-1:0]   r_above;
    logic [GRID_COLS-1:0]   r_here;

    logic [IDX_W-1:0]       in_idx;
    logic [CELLS_W-1:0]     in_cells;
    logic                   in_range;
    logic                   acc;
    logic                   slot_free;
    logic                   fin;
    logic [OP_W-1:0]        fin_op;
    logic [CELLS_W-1:0]     fin_row;
    logic                   last_pass;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   we;
    logic [AW-1:0]          wa;
    logic [GRID_COLS-1:0]   wd;
    logic [GRID_COLS-1:0]   below_row;
    logic [GRID_COLS-1:0]   new_row;

    assign in_idx   = s_axis_tdata[IDX_W-1:0];
    assign in_cells = s_axis_tdata[IDX_W +: CELLS_W];
    assign in_range = 32'(in_idx) < 32'(GRID_ROWS);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_out_valid || m_axis_tready;
    assign last_pass     = (r_pass + 4'd1) == r_pass_count;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_op;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_row);

    // completion of the current request
    always_comb begin
        fin     = 1'b0;
        fin_op  = s_axis_tuser;
        fin_row = '0;
        unique case (r_state)
            ST_IDLE: begin
                fin = acc && (s_axis_tuser != OP_READ)
                      && !((s_axis_tuser == OP_RUN) && (r_pass_count != '0));
            end
            ST_READ: begin
                fin    = 1'b1;
                fin_op = OP_READ;
                if (r_rd_inrange && r_rd_vld) begin
                    fin_row = CELLS_W'(r_rd_data);
                end
            end
            ST_RUN: begin
                fin    = (r_step == STEP_LAST) && last_pass;
                fin_op = OP_RUN;
            end
            ST_HOLD: begin
                fin = 1'b0;
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    // row window of the pass: old row above, old current row, old row below
    assign below_row = ((r_step <= STEP_ROWS) && r_rd_vld) ? r_rd_data : '0;

    cas_row #(
        .COLS (GRID_COLS)
    ) u_row (
        .i_above (r_above),
        .i_here  (r_here),
        .i_below (below_row),
        .i_rule  (r_rule),
        .o_row   (new_row)
    );

    // memory port selection
    always_comb begin
        if (r_state == ST_RUN) begin
            rd_en   = r_step < STEP_ROWS;
            rd_addr = r_step[AW-1:0];
            we      = r_step >= STEP_WB;
            wa      = AW'(r_step - STEP_WB);
            wd      = new_row;
        end else begin
            rd_en   = acc && (s_axis_tuser == OP_READ) && in_range;
            rd_addr = AW'(in_idx);
            we      = acc && (s_axis_tuser == OP_WRITE) && in_range;
            wa      = AW'(in_idx);
            wd      = GRID_COLS'(in_cells);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // rows never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (we) begin
                r_valid[wa] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_valid[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN) begin
            if (r_step == '0) begin
                r_above <= '0;
                r_here  <= '0;
            end else begin
                r_above <= r_here;
                r_here  <= below_row;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_count       <= PASS_COUNT_RST;
            r_rule.fill_above  <= FILL_ABOVE_RST;
            r_rule.clear_below <= CLEAR_BELOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PASS_COUNT:  r_pass_count       <= i_cfg_data;
                CFG_FILL_ABOVE:  r_rule.fill_above  <= i_cfg_data;
                CFG_CLEAR_BELOW: r_rule.clear_below <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= '0;
            r_pass       <= '0;
            r_rd_inrange <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (fin) begin
                if (slot_free) begin
                    r_out_valid <= 1'b1;
                    r_out_op    <= fin_op;
                    r_out_row   <= fin_row;
                    r_state     <= ST_IDLE;
                end else begin
                    r_pend_op   <= fin_op;
                    r_pend_row  <= fin_row;
                    r_state     <= ST_HOLD;
                end
            end else begin
                unique case (r_state)
                    ST_IDLE: begin
                        if (acc) begin
                            r_rd_inrange <= in_range;
                            r_step       <= '0;
                            r_pass       <= '0;
                            if (s_axis_tuser == OP_READ) begin
                                r_state <= ST_READ;
                            end else begin
                                r_state <= ST_RUN;
                            end
                        end
                    end
                    ST_RUN: begin
                        if (r_step == STEP_LAST) begin
                            r_step <= '0;
                            r_pass <= r_pass + 4'd1;
                        end else begin
                            r_step <= r_step + SW'(1);
                        end
                    end
                    ST_HOLD: begin
                        if (slot_free) begin
                            r_out_valid <= 1'b1;
                            r_out_op    <= r_pend_op;
                            r_out_row   <= r_pend_row;
                            r_state     <= ST_IDLE;
                        end
                    end
                    default: begin
                        r_state <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    // a run never goes past its configured pass count
    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_pass < r_pass_count))
        else $error("pass counter beyond pass count");

    // the row sweep stays inside one pass window
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_step <= STEP_LAST))
        else $error("row step beyond pass length");

    // outside a run, the grid is written only by an accepted row write
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && (r_state != ST_RUN)) |-> (acc && (s_axis_tuser == OP_WRITE)))
        else $error("grid written without a write request");

    // a written row is marked valid on the next cycle
    a_valid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (s_axis_tuser == OP_WRITE) && in_range) |=> r_valid[$past(wa)])
        else $error("row valid bit not set after write");

endmodule

>>> tb/cave_automaton_smoothing_tb.sv
// self-checking testbench for the cave smoothing automaton: row traffic, runs and rule settings
`timescale 1ns / 1ps
module cave_automaton_smoothing_tb;
    import cas_pkg::*;

    localparam int ROWS = 24;
    localparam int COLS = 36;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    // covers the longest run of 15 passes, plus margin
    localparam int TAIL_CYCLES = 420;
    localparam int PAD_W = IN_DATA_W - IDX_W - CELLS_W;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [CELLS_W-1:0] row;
    } t_reply;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OP_W-1:0]       m_axis_tuser;

    // shadow copy of the grid and the rule registers
    logic [CELLS_W-1:0]    shadow_grid [ROWS];
    logic [CFG_DATA_W-1:0] pass_count_q  = PASS_COUNT_RST;
    logic [CFG_DATA_W-1:0] fill_above_q  = FILL_ABOVE_RST;
    logic [CFG_DATA_W-1:0] clear_below_q = CLEAR_BELOW_RST;

    t_reply pending_replies [$];
    int     error_count = 0;
    int     quiet_cycles = 0;
    int     accepted_items = 0;
    int     run_count = 0;
    int     read_count = 0;
    int     reg_writes = 0;
    int     send_idle_pct = 15;
    int     recv_idle_pct = 74;

    cave_automaton_smoothing DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        for (int y = 0; y < ROWS; y++) shadow_grid[y] = '0;
    end

    // one double-buffered pass of the 4-5 style rule
    function automatic void smooth_grid();
        logic [CELLS_W-1:0] old_grid [ROWS];
        int count;
        old_grid = shadow_grid;
        for (int y = 0; y < ROWS; y++) begin
            for (int x = 0; x < COLS; x++) begin
                count = 0;
                for (int dy = -1; dy <= 1; dy++) begin
                    for (int dx = -1; dx <= 1; dx++) begin
                        if ((dy != 0 || dx != 0) && y + dy >= 0 && y + dy < ROWS
                                && x + dx >= 0 && x + dx < COLS)
                            count += old_grid[y + dy][x + dx];
                    end
                end
                // fill rule wins when both hold
                if (count > int'(fill_above_q))
                    shadow_grid[y][x] = 1'b1;
                else if (count < int'(clear_below_q))
                    shadow_grid[y][x] = 1'b0;
                else
                    shadow_grid[y][x] = old_grid[y][x];
            end
        end
    endfunction

    function automatic t_reply apply_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                             logic [CELLS_W-1:0] cells);
        t_reply r;
        r.op  = op;
        r.row = '0;
        case (op)
            OP_WRITE: begin
                if (idx < ROWS) shadow_grid[idx] = cells;
            end
            OP_RUN: begin
                for (int p = 0; p < int'(pass_count_q); p++) smooth_grid();
            end
            OP_READ: begin
                if (idx < ROWS) r.row = shadow_grid[idx];
            end
            default: ;
        endcase
        return r;
    endfunction

    // result check first, then prediction of the item accepted at this edge
    always @(posedge i_clk) begin
        t_reply want;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                $error("result with nothing outstanding: done_op %0d row_out %h",
                       m_axis_tuser, m_axis_tdata[CELLS_W-1:0]);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_axis_tuser !== want.op) begin
                    $error("done_op mismatch: expected %0d actual %0d", want.op, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[CELLS_W-1:0] !== want.row) begin
                    $error("row_out mismatch: expected %h actual %h",
                           want.row, m_axis_tdata[CELLS_W-1:0]);
                    error_count++;
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            accepted_items++;
            if (s_axis_tuser == OP_RUN) run_count++;
            if (s_axis_tuser == OP_READ) read_count++;
            pending_replies.insert(pending_replies.size(),
                                   apply_request(s_axis_tuser, s_axis_tdata[IDX_W-1:0],
                                                 s_axis_tdata[IDX_W +: CELLS_W]));
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(negedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic [CELLS_W-1:0] cells);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{PAD_W{1'b0}}, cells, idx};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        case (index)
            CFG_PASS_COUNT:  pass_count_q  = value;
            CFG_FILL_ABOVE:  fill_above_q  = value;
            CFG_CLEAR_BELOW: clear_below_q = value;
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_rules(input logic [CFG_DATA_W-1:0] passes,
                             input logic [CFG_DATA_W-1:0] fill,
                             input logic [CFG_DATA_W-1:0] clear);
        wait_idle();
        write_reg(CFG_PASS_COUNT, passes);
        write_reg(CFG_FILL_ABOVE, fill);
        write_reg(CFG_CLEAR_BELOW, clear);
    endtask

    function automatic logic [CELLS_W-1:0] rand_row(int pct);
        logic [CELLS_W-1:0] r;
        for (int b = 0; b < CELLS_W; b++) r[b] = ($urandom_range(99) < pct);
        return r;
    endfunction

    // uniformly random cell field, all bits
    function automatic logic [CELLS_W-1:0] rand_cells();
        return CELLS_W'({$urandom, $urandom});
    endfunction

    task automatic test_reset_state();
        send_request(OP_READ, 5'd0, '0);
        send_request(OP_READ, 5'd23, '1);
        send_request(OP_RUN, 5'd12, '0);
        send_request(OP_READ, 5'd12, '0);
    endtask

    task automatic test_row_extremes();
        send_request(OP_WRITE, 5'd0, '1);
        send_request(OP_WRITE, 5'd23, '1);
        // outside the grid: write dropped, read gives zero
        send_request(OP_WRITE, 5'd31, '1);
        send_request(OP_READ, 5'd31, '1);
        send_request(OP_WRITE, 5'd11, 36'hA_AAAA_AAAA);
        send_request(OP_READ, 5'd11, '0);
        send_request(OP_UNUSED, 5'd31, '1);
        send_request(OP_UNUSED, 5'd0, '0);
        send_request(OP_READ, 5'd23, '0);
    endtask

    task automatic test_rule_settings();
        // zero passes, both rules true, thresholds past eight, fill 0 / clear 8, max passes
        set_rules(4'd0, 4'd4, 4'd4);
        send_request(OP_WRITE, 5'd5, rand_row(50));
        send_request(OP_RUN, 5'd0, '0);
        send_request(OP_READ, 5'd5, '0);
        set_rules(4'd1, 4'd2, 4'd6);
        send_request(OP_RUN, 5'd0, '0);
        send_request(OP_READ, 5'd11, '0);
        set_rules(4'd1, 4'd15, 4'd15);
        send_request(OP_WRITE, 5'd6, rand_row(60));
        send_request(OP_RUN, 5'd0, '0);
        send_request(OP_READ, 5'd6, '0);
        set_rules(4'd1, 4'd0, 4'd8);
        send_request(OP_WRITE, 5'd7, rand_row(10));
        send_request(OP_RUN, 5'd0, '0);
        send_request(OP_READ, 5'd8, '0);
        set_rules(4'd15, 4'd8, 4'd0);
        send_request(OP_RUN, 5'd0, '0);
        send_request(OP_READ, 5'd7, '0);
    endtask

    task automatic send_noise();
        case ($urandom_range(2))
            0: send_request(OP_UNUSED, 5'($urandom), rand_cells());
            1: send_request(OP_WRITE, 5'($urandom_range(24, 31)), rand_cells());
            default: send_request(OP_READ, 5'($urandom_range(24, 31)), rand_cells());
        endcase
    endtask

    task automatic test_random_sessions(input int n_items, input int send_pct,
                                        input int recv_pct);
        int sent;
        int pct;
        int n;
        logic [CFG_DATA_W-1:0] passes;
        logic [CFG_DATA_W-1:0] fill;
        logic [CFG_DATA_W-1:0] clear;
        sent = 0;
        wait_idle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (sent < n_items) begin
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(9))
                    0:       passes = 4'($urandom_range(9, 15));
                    1, 2:    passes = 4'($urandom_range(4, 8));
                    default: passes = 4'($urandom_range(0, 3));
                endcase
                fill  = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
                clear = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
                set_rules(passes, fill, clear);
            end
            case ($urandom_range(5))
                0:       pct = $urandom_range(0, 100);
                1:       pct = 50;
                default: pct = $urandom_range(40, 60);
            endcase
            // seed the grid: mostly a full frame, otherwise a few scattered rows
            if ($urandom_range(9) < 7) begin
                for (int y = 0; y < ROWS; y++) begin
                    if ($urandom_range(99) < 5) send_noise();
                    send_request(OP_WRITE, 5'(y), rand_row(pct));
                    sent++;
                end
            end else begin
                n = $urandom_range(0, 6);
                for (int k = 0; k < n; k++) begin
                    send_request(OP_WRITE, 5'($urandom_range(0, ROWS - 1)), rand_row(pct));
                    sent++;
                end
            end
            n = ($urandom_range(4) == 0) ? 2 : 1;
            for (int k = 0; k < n; k++) begin
                send_request(OP_RUN, 5'($urandom), rand_cells());
                sent++;
            end
            if ($urandom_range(9) < 6) begin
                for (int y = 0; y < ROWS; y++) begin
                    if ($urandom_range(99) < 5) send_noise();
                    send_request(OP_READ, 5'(y), rand_cells());
                    sent++;
                end
            end else begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++) begin
                    send_request(OP_READ, 5'($urandom_range(0, ROWS - 1)), rand_cells());
                    sent++;
                end
                send_noise();
            end
        end
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_row_extremes();
        test_rule_settings();
        test_random_sessions(380, 15, 74);
        test_random_sessions(380, 74, 15);
        test_random_sessions(380, 0, 0);
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_replies.size() != 0) begin
            $error("%0d results never arrived", pending_replies.size());
            error_count++;
        end
        $display("run covered %0d requests: %0d smoothing runs, %0d row reads", accepted_items,
                 run_count, read_count);
        $display("rule registers written %0d times, %0d check failures", reg_writes,
                 error_count);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
